FILE: hdl/segment_color_histogram_assert.svh
// Assertion macros for the segment colour histogram.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message.
`ifndef SEGMENT_COLOR_HISTOGRAM_ASSERT_SVH
`define SEGMENT_COLOR_HISTOGRAM_ASSERT_SVH

`ifndef ASSERT_OFF
`define SCH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/schist_pkg.sv
package schist_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int MAX_BINS     = 8;
  localparam int COUNT_BITS   = 20;

  // Port field widths
  localparam int SEG_W = 6;
  localparam int VAL_W = 8;
  localparam int BIN_W = 3;
  localparam int CFG_W = 4;

  localparam int SEG_BITS  = $clog2(MAX_SEGMENTS);
  localparam int BIN_BITS  = $clog2(MAX_BINS);
  localparam int ADDR_W    = SEG_BITS + 3 * BIN_BITS;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int PROD_W    = VAL_W + BIN_BITS;

  localparam logic [CFG_W-1:0]      BINS_RESET = CFG_W'(8);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Back-end operation classes
  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_ZERO
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
  } job_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // floor(v * bm1 / 255) by reciprocal: (p + (p >> 8) + 1) >> 8 is exact for p < 65535
  function automatic logic [BIN_BITS-1:0] quantize(logic [VAL_W-1:0] v,
                                                   logic [BIN_BITS-1:0] bm1);
    logic [PROD_W-1:0] p;
    logic [PROD_W:0]   s;
    p = PROD_W'(v) * PROD_W'(bm1);
    s = (PROD_W + 1)'(p) + (PROD_W + 1)'(p >> VAL_W) + (PROD_W + 1)'(1);
    return BIN_BITS'(s >> VAL_W);
  endfunction

endpackage

FILE: hdl/schist_if.sv
interface schist_pix_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [schist_pkg::SEG_W-1:0] segment;
  logic [schist_pkg::VAL_W-1:0] red;
  logic [schist_pkg::VAL_W-1:0] green;
  logic [schist_pkg::VAL_W-1:0] blue;
  logic [schist_pkg::BIN_W-1:0] red_bin;
  logic [schist_pkg::BIN_W-1:0] green_bin;
  logic [schist_pkg::BIN_W-1:0] blue_bin;

  modport source (output valid, command, segment, red, green, blue,
                  red_bin, green_bin, blue_bin, input ready);
  modport sink   (input valid, command, segment, red, green, blue,
                  red_bin, green_bin, blue_bin, output ready);
endinterface

interface schist_cnt_if;
  logic                              valid;
  logic                              ready;
  logic [schist_pkg::COUNT_BITS-1:0] bin_count;

  modport source (output valid, bin_count, input ready);
  modport sink   (input valid, bin_count, output ready);
endinterface

interface schist_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [schist_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/schist_front.sv
module schist_front (
  input  logic                   clk,
  input  logic                   rst_n,
  schist_pix_if.sink             in_ch,
  schist_cfg_if.sink             cfg_ch,
  input  schist_pkg::back_stat_t stat,
  input  logic                   q_full,
  output logic                   q_push,
  output schist_pkg::job_t       q_job
);

  logic [schist_pkg::CFG_W-1:0]    bins_r;
  logic [schist_pkg::CFG_W-1:0]    eff_bins;
  logic [schist_pkg::BIN_BITS-1:0] bm1;
  logic [schist_pkg::BIN_BITS-1:0] rq, gq, bq;
  logic [schist_pkg::SEG_BITS-1:0] seg;
  logic                            seg_ok, idx_ok, accept;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= schist_pkg::BINS_RESET;
    end else if (cfg_ch.valid) begin
      bins_r <= cfg_ch.data;
    end
  end

  always_comb begin
    // clamp the bin setting to one .. MAX_BINS
    priority if (bins_r == '0) begin
      eff_bins = schist_pkg::CFG_W'(1);
    end else if (int'(bins_r) > schist_pkg::MAX_BINS) begin
      eff_bins = schist_pkg::CFG_W'(schist_pkg::MAX_BINS);
    end else begin
      eff_bins = bins_r;
    end
    bm1 = schist_pkg::BIN_BITS'(eff_bins - schist_pkg::CFG_W'(1));

    rq  = schist_pkg::quantize(in_ch.red, bm1);
    gq  = schist_pkg::quantize(in_ch.green, bm1);
    bq  = schist_pkg::quantize(in_ch.blue, bm1);
    seg = schist_pkg::SEG_BITS'(in_ch.segment);

    seg_ok = int'(in_ch.segment) < schist_pkg::MAX_SEGMENTS;
    idx_ok = (int'(in_ch.red_bin) < schist_pkg::MAX_BINS) &&
             (int'(in_ch.green_bin) < schist_pkg::MAX_BINS) &&
             (int'(in_ch.blue_bin) < schist_pkg::MAX_BINS);

    in_ch.ready = !q_full && !stat.clearing;
    accept      = in_ch.valid && in_ch.ready;

    // drop adds to a segment out of range; reads always give a result
    q_push = accept && (in_ch.command == schist_pkg::CMD_READ || seg_ok);

    if (in_ch.command == schist_pkg::CMD_ADD) begin
      q_job.op   = schist_pkg::OP_ADD;
      q_job.addr = {seg, rq, gq, bq};
    end else begin
      q_job.op   = (seg_ok && idx_ok) ? schist_pkg::OP_READ : schist_pkg::OP_ZERO;
      q_job.addr = {seg, schist_pkg::BIN_BITS'(in_ch.red_bin),
                    schist_pkg::BIN_BITS'(in_ch.green_bin),
                    schist_pkg::BIN_BITS'(in_ch.blue_bin)};
    end
  end

endmodule

FILE: hdl/schist_queue.sv
module schist_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  schist_pkg::job_t push_job,
  input  logic             pop,
  output schist_pkg::job_t head_job,
  output logic             empty,
  output logic             full
);

  schist_pkg::job_t                entries_r [schist_pkg::QUEUE_DEPTH];
  logic [schist_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [schist_pkg::QPTR_W:0]     count_r;

  assign empty    = count_r == '0;
  assign full     = count_r == (schist_pkg::QPTR_W + 1)'(schist_pkg::QUEUE_DEPTH);
  assign head_job = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + schist_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + schist_pkg::QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + (schist_pkg::QPTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (schist_pkg::QPTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: hdl/schist_back.sv
`include "segment_color_histogram_assert.svh"

module schist_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  schist_pkg::job_t        q_job,
  output logic                    q_pop,
  output schist_pkg::back_stat_t  stat,
  schist_cnt_if.source            out_ch
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD
  } state_t;

  state_t                            state_r;
  logic [schist_pkg::ADDR_W-1:0]     clr_addr_r;
  logic [schist_pkg::ADDR_W-1:0]     addr_r;
  schist_pkg::op_t                   op_r;
  logic                              out_valid_r;
  logic [schist_pkg::COUNT_BITS-1:0] out_data_r;
  logic [schist_pkg::COUNT_BITS-1:0] rd_data_r;

  logic [schist_pkg::COUNT_BITS-1:0] mem [schist_pkg::MEM_DEPTH];

  logic                              out_free, out_load, rd_en, wr_en;
  logic [schist_pkg::ADDR_W-1:0]     wr_addr;
  logic [schist_pkg::COUNT_BITS-1:0] wr_data;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.bin_count = out_data_r;
  assign stat.clearing    = state_r == ST_CLEAR;

  always_comb begin
    out_free = !out_valid_r || out_ch.ready;
    q_pop    = (state_r == ST_IDLE) && !q_empty && out_free;
    rd_en    = q_pop && (q_job.op != schist_pkg::OP_ZERO);
    // a count leaves on a read that skips memory, or once the read-back is in
    out_load = (q_pop && (q_job.op == schist_pkg::OP_ZERO)) ||
               ((state_r == ST_MOD) && (op_r == schist_pkg::OP_READ));
    wr_en    = 1'b0;
    wr_addr  = addr_r;
    wr_data  = '0;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
      end
      ST_MOD: begin
        wr_en = 1'b1;
        if (op_r == schist_pkg::OP_ADD) begin
          // saturate at full scale
          wr_data = (rd_data_r == schist_pkg::COUNT_MAX) ? rd_data_r
                  : rd_data_r + schist_pkg::COUNT_BITS'(1);
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[q_job.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a new count, else drop the one the sink has taken
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= (state_r == ST_MOD) ? rd_data_r : '0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + schist_pkg::ADDR_W'(1);
          if (clr_addr_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (rd_en) begin
            op_r    <= q_job.op;
            addr_r  <= q_job.addr;
            state_r <= ST_MOD;
          end
        end
        ST_MOD: begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `SCH_ASSERT_IMPL(a_no_pop_in_clear, clk, rst_n, state_r == ST_CLEAR, !q_pop, "pop during clear")
  `SCH_ASSERT_NEXT(a_mem_pop_to_mod, clk, rst_n, rd_en, state_r == ST_MOD, "missed update cycle")
  `SCH_ASSERT_IMPL(a_out_from_job, clk, rst_n, $rose(out_valid_r), $past(out_load), "stray result")
  `SCH_ASSERT_NEXT(a_mod_one_cycle, clk, rst_n, state_r == ST_MOD, state_r == ST_IDLE, "update stuck")

endmodule

FILE: hdl/segment_color_histogram.sv
// Segment colour histogram: 64 segments x 8x8x8 bins of 20-bit saturating counters.
// An add or a read in range holds the update unit for a memory read and the modify
// state; a read result is registered from the read-back, one out of range straight
// from the queue head. The read-modify-write of the single-port counter memory keeps
// items out in the modify state, as does a stalled out_ch. Reset (rst_n, synchronous)
// zeroes all 32768 counters, one a cycle, with in_ch.ready low; config is taken.
module segment_color_histogram (
  input  logic          clk,
  input  logic          rst_n,
  schist_pix_if.sink    in_ch,
  schist_cnt_if.source  out_ch,
  schist_cfg_if.sink    cfg_ch
);

  // Front to queue: classified requests with their counter address
  logic                   q_push;
  schist_pkg::job_t       q_push_job;
  // Queue to back: head request and occupancy
  logic                   q_pop;
  schist_pkg::job_t       q_head_job;
  logic                   q_empty;
  logic                   q_full;
  // Back status: hold input off during the clearing sweep
  schist_pkg::back_stat_t stat;

  // Quantize colours, check ranges and form the counter address
  schist_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .stat   (stat),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_push_job)
  );

  // Decouple acceptance from the memory update
  schist_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head_job (q_head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Read-modify-write the counter memory and register the result
  schist_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (q_head_job),
    .q_pop   (q_pop),
    .stat    (stat),
    .out_ch  (out_ch)
  );

endmodule
